@@ src/xts_pkg.sv @@
// shared types, constants and the gamma power table for the xyz to srgb pixel block
`timescale 1ns / 1ps

package xts_pkg;

    // field widths
    localparam int IN_W   = 18;
    localparam int OUT_W  = 16;
    localparam int COEF_W = 19;
    localparam int PROD_W = IN_W + COEF_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int LIN_W  = 17;
    localparam int FRAC_W = 16;

    // power table geometry
    localparam int GAMMA_TABLE_SIZE = 256;
    localparam int GT_LAST          = GAMMA_TABLE_SIZE - 1;
    localparam int GT_IDX_W         = $clog2(GAMMA_TABLE_SIZE);
    localparam int GT_W             = 17;

    // encoding constants, Q.16 unless noted; PW_OFFSET is Q.32
    localparam int  LIN_FULL   = 65536;
    localparam int  OUT_MAX    = 65535;
    localparam int  ROUND_HALF = 32768;
    localparam int  LIN_KNEE   = 205;
    localparam int  LIN_SLOPE  = 846725;
    localparam int  LIN_SLOPE_W = 20;
    localparam int  PW_GAIN    = 69140;
    localparam int  PW_OFFSET  = 236223201;

    // lane pipeline depth
    localparam int LANE_STAGES = 6;

    // one matrix row
    typedef struct packed {
        logic signed [COEF_W-1:0] cx;
        logic signed [COEF_W-1:0] cy;
        logic signed [COEF_W-1:0] cz;
    } t_row;

    localparam t_row ROW_RED   = '{cx: 19'sd212366, cy: -19'sd100738, cz: -19'sd32672};
    localparam t_row ROW_GREEN = '{cx: -19'sd63522, cy: 19'sd122946, cz: 19'sd2723};
    localparam t_row ROW_BLUE  = '{cx: 19'sd3647, cy: -19'sd13371, cz: 19'sd69286};

    // stage enables from the merge stage to the lanes
    typedef struct packed {
        logic [LANE_STAGES-1:0] en;
    } t_ctl;

    // lane results
    typedef struct packed {
        logic [OUT_W-1:0] blue;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] red;
    } t_rgb;

    typedef logic [GAMMA_TABLE_SIZE-1:0][GT_W-1:0] t_gtab;

    // floor of the square root, bit by bit
    function automatic logic [63:0] root2(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = n_in;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // floor of the cube root, binary search
    function automatic logic [63:0] root3(input logic [63:0] n);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = '0;
        hi = 64'd1 << 20;
        for (int j = 0; j < 24; j++) begin
            if (lo < hi) begin
                mid = (lo + hi + 64'd1) >> 1;
                if (mid * mid * mid <= n) begin
                    lo = mid;
                end else begin
                    hi = mid - 64'd1;
                end
            end
        end
        return lo;
    endfunction

    // node i holds (i / last)^(1/2.4) in Q.16
    function automatic logic [GT_W-1:0] gtab_node(input int i);
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] q;
        logic [63:0] w;
        logic [63:0] r;
        logic [63:0] e;
        a = (64'(i) << 30) / 64'(GT_LAST);
        s = root2(a << 30);
        q = root2(s << 30);
        w = (a * q) >> 30;
        r = root3(w << 30);
        e = (r + 64'd8) >> 4;
        if (e > 64'(LIN_FULL)) begin
            e = 64'(LIN_FULL);
        end
        return e[GT_W-1:0];
    endfunction

    function automatic t_gtab build_gtab();
        t_gtab t;
        for (int i = 0; i < GAMMA_TABLE_SIZE; i++) begin
            t[i] = gtab_node(i);
        end
        return t;
    endfunction

    localparam t_gtab GTAB = build_gtab();

endpackage

@@ src/xts_if.sv @@
// pixel input and output channel interfaces
`timescale 1ns / 1ps

interface xts_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [xts_pkg::IN_W-1:0]   x_in;
    logic signed [xts_pkg::IN_W-1:0]   y_in;
    logic signed [xts_pkg::IN_W-1:0]   z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface xts_out_if;
    logic                        valid;
    logic                        ready;
    logic [xts_pkg::OUT_W-1:0]   blue_out;
    logic [xts_pkg::OUT_W-1:0]   green_out;
    logic [xts_pkg::OUT_W-1:0]   red_out;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    output ready);
endinterface

@@ src/xts_lane.sv @@
// one color channel lane: matrix row, clamp and gamma encode in six stages
`timescale 1ns / 1ps

module xts_lane (
    input  logic                                i_clk,
    input  xts_pkg::t_ctl                       i_ctl,
    input  xts_pkg::t_row                       i_row,
    input  logic signed [xts_pkg::IN_W-1:0]     i_x,
    input  logic signed [xts_pkg::IN_W-1:0]     i_y,
    input  logic signed [xts_pkg::IN_W-1:0]     i_z,
    output logic [xts_pkg::OUT_W-1:0]           o_enc
);

    localparam int POS_W  = xts_pkg::LIN_W + xts_pkg::GT_IDX_W;
    localparam int LINP_W = xts_pkg::LIN_W + xts_pkg::LIN_SLOPE_W;
    localparam int DF_W   = xts_pkg::GT_W + xts_pkg::FRAC_W;
    localparam int GAIN_W = 34;
    localparam int U_W    = GAIN_W + 1;

    // stage 1: products
    logic signed [xts_pkg::PROD_W-1:0] r_px, r_py, r_pz;
    // stage 2: linear value
    logic [xts_pkg::LIN_W-1:0] r_lin;
    // stage 3: table position and linear segment
    logic [xts_pkg::GT_IDX_W-1:0] r_k;
    logic [xts_pkg::FRAC_W-1:0]   r_f;
    logic                         r_small3, r_small4, r_small5;
    logic [xts_pkg::OUT_W-1:0]    r_lo3, r_lo4, r_lo5;
    // stage 4: node and weighted step
    logic [xts_pkg::GT_W-1:0]     r_t0;
    logic [DF_W-1:0]              r_df;
    // stage 5: interpolated power
    logic [xts_pkg::GT_W-1:0]     r_p;
    // stage 6: encoded result
    logic [xts_pkg::OUT_W-1:0]    r_enc;

    logic signed [xts_pkg::PROD_W-1:0] n_px, n_py, n_pz;
    logic signed [xts_pkg::SUM_W-1:0]  n_sum, n_sum_r;
    logic [xts_pkg::SUM_W-17:0]        n_rnd;
    logic [xts_pkg::LIN_W-1:0]         n_lin;
    logic [POS_W-1:0]                  n_pos;
    logic [LINP_W-1:0]                 n_linp;
    logic [xts_pkg::GT_IDX_W-1:0]      n_k1;
    logic [xts_pkg::GT_W-1:0]          n_t0, n_t1, n_d;
    logic [DF_W:0]                     n_df_r;
    logic [GAIN_W-1:0]                 n_gain;
    logic signed [U_W-1:0]             n_u, n_u_r;
    logic [xts_pkg::LIN_W-1:0]         n_pw;
    logic [xts_pkg::OUT_W-1:0]         n_enc;

    // row products
    assign n_px = i_x * i_row.cx;
    assign n_py = i_y * i_row.cy;
    assign n_pz = i_z * i_row.cz;

    // sum, round to Q.16 and clamp to 0..1
    assign n_sum   = xts_pkg::SUM_W'(r_px) + xts_pkg::SUM_W'(r_py) + xts_pkg::SUM_W'(r_pz);
    assign n_sum_r = n_sum + xts_pkg::SUM_W'(xts_pkg::ROUND_HALF);
    assign n_rnd   = n_sum_r[xts_pkg::SUM_W-1:16];

    always_comb begin
        if (n_sum[xts_pkg::SUM_W-1] || n_sum == '0) begin
            n_lin = '0;
        end else if (n_rnd > (xts_pkg::SUM_W-16)'(xts_pkg::LIN_FULL)) begin
            n_lin = xts_pkg::LIN_W'(xts_pkg::LIN_FULL);
        end else begin
            n_lin = n_rnd[xts_pkg::LIN_W-1:0];
        end
    end

    // table position and linear segment near black
    assign n_pos  = POS_W'(r_lin) * POS_W'(xts_pkg::GT_LAST);
    assign n_linp = LINP_W'(r_lin) * LINP_W'(xts_pkg::LIN_SLOPE)
                  + LINP_W'(xts_pkg::ROUND_HALF);

    // table read at the node and its successor
    assign n_k1 = (r_k == xts_pkg::GT_IDX_W'(xts_pkg::GT_LAST)) ? r_k
                                                                 : r_k + 1'b1;
    assign n_t0 = xts_pkg::GTAB[r_k];
    assign n_t1 = xts_pkg::GTAB[n_k1];
    assign n_d  = n_t1 - n_t0;

    // interpolation
    assign n_df_r = (DF_W + 1)'(r_df) + (DF_W + 1)'(xts_pkg::ROUND_HALF);

    // power segment: 1.055 * p - 0.055
    assign n_gain = GAIN_W'(r_p) * GAIN_W'(xts_pkg::PW_GAIN);
    assign n_u    = $signed({1'b0, n_gain}) - $signed(U_W'(xts_pkg::PW_OFFSET));
    assign n_u_r  = n_u + U_W'(xts_pkg::ROUND_HALF);
    assign n_pw   = n_u_r[32:16];

    always_comb begin
        if (r_small5) begin
            n_enc = r_lo5;
        end else if (n_u[U_W-1]) begin
            n_enc = '0;
        end else if (n_pw > xts_pkg::LIN_W'(xts_pkg::OUT_MAX)) begin
            n_enc = xts_pkg::OUT_W'(xts_pkg::OUT_MAX);
        end else begin
            n_enc = n_pw[xts_pkg::OUT_W-1:0];
        end
    end

    // node plus rounded fraction of the step
    function automatic logic [xts_pkg::GT_W-1:0] n_t0_sum(
        input logic [xts_pkg::GT_W-1:0] t0,
        input logic [DF_W:0]            dfr
    );
        return t0 + dfr[16 +: xts_pkg::GT_W];
    endfunction

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_px <= n_px;
            r_py <= n_py;
            r_pz <= n_pz;
        end
        if (i_ctl.en[1]) begin
            r_lin <= n_lin;
        end
        if (i_ctl.en[2]) begin
            r_k      <= n_pos[16 +: xts_pkg::GT_IDX_W];
            r_f      <= n_pos[xts_pkg::FRAC_W-1:0];
            r_small3 <= (r_lin <= xts_pkg::LIN_W'(xts_pkg::LIN_KNEE));
            r_lo3    <= n_linp[16 +: xts_pkg::OUT_W];
        end
        if (i_ctl.en[3]) begin
            r_t0     <= n_t0;
            r_df     <= DF_W'(n_d) * DF_W'(r_f);
            r_small4 <= r_small3;
            r_lo4    <= r_lo3;
        end
        if (i_ctl.en[4]) begin
            r_p      <= n_t0_sum(r_t0, n_df_r);
            r_small5 <= r_small4;
            r_lo5    <= r_lo4;
        end
        if (i_ctl.en[5]) begin
            r_enc <= n_enc;
        end
    end

    assign o_enc = r_enc;

endmodule

@@ src/xts_merge.sv @@
// merge stage: stage valid chain, lane result register and channel handshake
`timescale 1ns / 1ps

module xts_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    xts_in_if.sink          i_pix,
    xts_out_if.source       o_pix,
    input  xts_pkg::t_rgb   i_enc,
    output xts_pkg::t_ctl   o_ctl
);

    logic [xts_pkg::LANE_STAGES-1:0] r_v;
    logic                            r_out_v;
    xts_pkg::t_rgb                   r_out;
    logic                            n_en_out;
    logic [xts_pkg::LANE_STAGES-1:0] n_en;

    // a stage moves when it is empty or the next one moves
    assign n_en_out = !r_out_v || o_pix.ready;

    always_comb begin
        n_en[xts_pkg::LANE_STAGES-1] = !r_v[xts_pkg::LANE_STAGES-1] || n_en_out;
        for (int s = xts_pkg::LANE_STAGES - 2; s >= 0; s--) begin
            n_en[s] = !r_v[s] || n_en[s+1];
        end
    end

    assign o_ctl.en    = n_en;
    assign i_pix.ready = n_en[0];

    // valid bits of the lane stages and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_pix.valid;
            end
            for (int s = 1; s < xts_pkg::LANE_STAGES; s++) begin
                if (n_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            if (n_en_out) begin
                r_out_v <= r_v[xts_pkg::LANE_STAGES-1];
            end
        end
    end

    // combined result of the three lanes
    always_ff @(posedge i_clk) begin
        if (n_en_out) begin
            r_out <= i_enc;
        end
    end

    assign o_pix.valid     = r_out_v;
    assign o_pix.blue_out  = r_out.blue;
    assign o_pix.green_out = r_out.green;
    assign o_pix.red_out   = r_out.red;

endmodule

@@ src/xyz_to_srgb_pixel.sv @@
// top level: three color lanes side by side and the merge stage
// path: an accepted item passes the six lane stages and then one output register
// throughput: one item per cycle while the output is not stalled; each lane is a pipeline whose
// multiplies sit in stages 1, 3, 4 and 6; stalls ripple back stage by stage, so empty stages
// fill while a result waits; reset: synchronous, active low; clears the stage valid bits and the output valid
// the gamma table is constant logic, so no clearing pass follows reset
`timescale 1ns / 1ps

module xyz_to_srgb_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    xts_in_if.sink      i_pix,
    xts_out_if.source   o_pix
);

    xts_pkg::t_ctl w_ctl;
    xts_pkg::t_rgb w_enc;

    // one lane per output channel
    xts_lane u_lane_blue (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_row (xts_pkg::ROW_BLUE),
        .i_x   (i_pix.x_in),
        .i_y   (i_pix.y_in),
        .i_z   (i_pix.z_in),
        .o_enc (w_enc.blue)
    );

    xts_lane u_lane_green (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_row (xts_pkg::ROW_GREEN),
        .i_x   (i_pix.x_in),
        .i_y   (i_pix.y_in),
        .i_z   (i_pix.z_in),
        .o_enc (w_enc.green)
    );

    xts_lane u_lane_red (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .i_row (xts_pkg::ROW_RED),
        .i_x   (i_pix.x_in),
        .i_y   (i_pix.y_in),
        .i_z   (i_pix.z_in),
        .o_enc (w_enc.red)
    );

    // merge stage and handshake
    xts_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .o_pix   (o_pix),
        .i_enc   (w_enc),
        .o_ctl   (w_ctl)
    );

    // input only backs up when every stage holds an item and the output is stalled
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (o_pix.valid && !o_pix.ready))
        else $error("input stalled while the pipeline has room");

    // with the output always ready, an accepted item passes every lane stage and reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && o_pix.ready) ##1 o_pix.ready ##1 o_pix.ready
        ##1 o_pix.ready ##1 o_pix.ready ##1 o_pix.ready ##1 o_pix.ready
        |=> o_pix.valid)
        else $error("item did not reach the output in seven cycles");

    // reset leaves no result and an open input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_pix.valid && i_pix.ready))
        else $error("pipeline not empty after reset");

endmodule
